>>> design/gip_pkg.sv
// Shared constants for the ground-to-image projection block: register codes,
// reset values, fixed field widths and the CORDIC arctangent constants.
// No dependencies.
package gip_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF = 18;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 31;
	localparam logic [ADDR_W-1:0] REG_FOCAL_X = 3'd0;
	localparam logic [ADDR_W-1:0] REG_FOCAL_Y = 3'd1;
	localparam logic [ADDR_W-1:0] REG_CENTER_X = 3'd2;
	localparam logic [ADDR_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [ADDR_W-1:0] REG_MOUNT = 3'd4;
	localparam logic [ADDR_W-1:0] REG_PITCH = 3'd5;
	localparam logic [ADDR_W-1:0] REG_YAW = 3'd6;

	localparam logic [12:0] FOCAL_X_RST = 13'd1000;
	localparam logic [12:0] FOCAL_Y_RST = 13'd1000;
	localparam logic [12:0] CENTER_X_RST = 13'd640;
	localparam logic [12:0] CENTER_Y_RST = 13'd360;
	localparam logic [30:0] MOUNT_RST = 31'd98304;

	// Field and datapath widths.
	localparam int PIX_W = 13;
	localparam int ANG_W = 24;
	localparam int GND_W = 32;
	localparam int OUT_W = 32;
	localparam int TRIG_W = 20;
	localparam int TRIG_FRAC = 18;
	localparam int CORD_W = 33;
	localparam int ZW = 26;
	localparam int ITER_W = 5;
	localparam int ATAN_DEPTH = 24;
	localparam int MAT_W = 52;
	localparam int MAT_LO_W = 26;
	localparam int QV_W = 35;
	localparam int ROW_W = 85;
	localparam int QUO_W = 32;

	localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;
	localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [CORD_W-1:0] TRIG_ROUND = 33'sd2048;
	localparam logic signed [CORD_W-1:0] TRIG_ONE = 33'sd262144;
	localparam int TRIG_SHIFT = 12;

	// Arctangent of 2^-i in Q8.16 degrees.
	function automatic logic signed [ZW-1:0] atan_deg(input logic [ITER_W-1:0] i);
		case (i)
			5'd0: atan_deg = 26'sd2949120;
			5'd1: atan_deg = 26'sd1740967;
			5'd2: atan_deg = 26'sd919879;
			5'd3: atan_deg = 26'sd466945;
			5'd4: atan_deg = 26'sd234379;
			5'd5: atan_deg = 26'sd117304;
			5'd6: atan_deg = 26'sd58666;
			5'd7: atan_deg = 26'sd29335;
			5'd8: atan_deg = 26'sd14668;
			5'd9: atan_deg = 26'sd7334;
			5'd10: atan_deg = 26'sd3667;
			5'd11: atan_deg = 26'sd1833;
			5'd12: atan_deg = 26'sd917;
			5'd13: atan_deg = 26'sd458;
			5'd14: atan_deg = 26'sd229;
			5'd15: atan_deg = 26'sd115;
			5'd16: atan_deg = 26'sd57;
			5'd17: atan_deg = 26'sd29;
			5'd18: atan_deg = 26'sd14;
			5'd19: atan_deg = 26'sd7;
			5'd20: atan_deg = 26'sd4;
			5'd21: atan_deg = 26'sd2;
			5'd22: atan_deg = 26'sd1;
			default: atan_deg = 26'sd0;
		endcase
	endfunction

endpackage

>>> design/ground_to_image_projection.sv
// Top level of the ground-to-image projection block: trig sequencer, matrix
// setup pipeline, projection pipeline and pipelined divider.
// Depends on gip_pkg.

// The block takes one ground point per clock while busy is low and returns
// its image column and row, one result per point, in order. A point is taken
// at a clock edge where start is high and busy is low; the result stands on
// pixel_u, pixel_v and divide_fault for exactly one cycle, marked by done,
// and the receiver must take it then. Busy is high only while the camera
// setup is being worked out: after reset and after every register write, one
// shared CORDIC unit computes the cosine and sine of pitch and then of yaw,
// one rotation per cycle, and a three-stage pipeline then builds the
// projection matrix. Once busy is low, a point can be started in every cycle.
// The pipeline holds the 32 one-bit stages of the divider that forms the
// quotients, plus nine further stages: input capture, multiply, product merge,
// two row additions, magnitude, numerator setup, divider setup and output
// saturation.
module ground_to_image_projection #(
	parameter int FRAC_BITS = gip_pkg::FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = gip_pkg::TRIG_ITER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gip_pkg::ADDR_W-1:0]           cfg_addr,
	input  logic [gip_pkg::DATA_W-1:0]           cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [gip_pkg::GND_W-1:0]     ground_x,
	input  logic signed [gip_pkg::GND_W-1:0]     ground_y,
	output logic                                 done,
	output logic signed [gip_pkg::OUT_W-1:0]     pixel_u,
	output logic signed [gip_pkg::OUT_W-1:0]     pixel_v,
	output logic                                 divide_fault
);

	localparam int N_ITER = (TRIG_ITERATIONS > gip_pkg::ATAN_DEPTH) ?
		gip_pkg::ATAN_DEPTH : TRIG_ITERATIONS;
	localparam int CW = gip_pkg::CORD_W;
	localparam int ZW = gip_pkg::ZW;
	localparam int TW = gip_pkg::TRIG_W;
	localparam int TS = gip_pkg::TRIG_FRAC;
	localparam int MW = gip_pkg::MAT_W;
	localparam int LO_W = gip_pkg::MAT_LO_W;
	localparam int HI_W = MW - LO_W;
	localparam int PW = gip_pkg::GND_W;
	localparam int PPW = LO_W + 1 + PW;
	localparam int QV_W = gip_pkg::QV_W;
	localparam int RW = gip_pkg::ROW_W;
	localparam int NW = RW + FRAC_BITS + 2;
	localparam int DW = RW + 1;
	localparam int QW = gip_pkg::QUO_W;
	localparam int LAT = 9 + QW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_RUN = 3'd2;
	localparam logic [2:0] S_STORE = 3'd3;
	localparam logic [2:0] S_SETTLE = 3'd4;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [gip_pkg::PIX_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [30:0] mount_q;
	logic [gip_pkg::ANG_W-1:0] pitch_q, yaw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= gip_pkg::FOCAL_X_RST;
			focal_y_q <= gip_pkg::FOCAL_Y_RST;
			center_x_q <= gip_pkg::CENTER_X_RST;
			center_y_q <= gip_pkg::CENTER_Y_RST;
			mount_q <= gip_pkg::MOUNT_RST;
			pitch_q <= '0;
			yaw_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				gip_pkg::REG_FOCAL_X: focal_x_q <= cfg_wdata[gip_pkg::PIX_W-1:0];
				gip_pkg::REG_FOCAL_Y: focal_y_q <= cfg_wdata[gip_pkg::PIX_W-1:0];
				gip_pkg::REG_CENTER_X: center_x_q <= cfg_wdata[gip_pkg::PIX_W-1:0];
				gip_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata[gip_pkg::PIX_W-1:0];
				gip_pkg::REG_MOUNT: mount_q <= cfg_wdata[30:0];
				gip_pkg::REG_PITCH: pitch_q <= cfg_wdata[gip_pkg::ANG_W-1:0];
				gip_pkg::REG_YAW: yaw_q <= cfg_wdata[gip_pkg::ANG_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Trig sequencer: one CORDIC rotation per cycle, pitch then yaw.
	// Any register write restarts the whole setup so the matrix is
	// always rebuilt from the current registers.
	// ---------------------------------------------------------------
	logic [2:0] st_q;
	logic sel_q;
	logic [gip_pkg::ITER_W-1:0] iter_q;
	logic [1:0] settle_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic flip_q;
	logic signed [TW-1:0] c1_q, s1_q, c2_q, s2_q;

	logic signed [gip_pkg::ANG_W-1:0] ang;
	logic signed [ZW-1:0] z_raw, z_fold;
	logic fold;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] at;
	logic signed [TW-1:0] tc, ts;

	function automatic logic signed [TW-1:0] to_trig(input logic signed [CW-1:0] v,
		input logic neg);
		logic signed [CW-1:0] r;
		logic signed [CW-1:0] c;
		r = (v + gip_pkg::TRIG_ROUND) >>> gip_pkg::TRIG_SHIFT;
		if (r > gip_pkg::TRIG_ONE) begin
			c = gip_pkg::TRIG_ONE;
		end else if (r < -gip_pkg::TRIG_ONE) begin
			c = -gip_pkg::TRIG_ONE;
		end else begin
			c = r;
		end
		if (neg) begin
			c = -c;
		end
		to_trig = c[TW-1:0];
	endfunction

	assign ang = sel_q ? yaw_q : pitch_q;
	assign z_raw = {{(ZW - gip_pkg::ANG_W){ang[gip_pkg::ANG_W-1]}}, ang};

	// Angles past a quarter turn are folded by a half turn; the results are
	// negated at the end to compensate.
	always_comb begin
		fold = 1'b0;
		z_fold = z_raw;
		if (z_raw > gip_pkg::DEG90) begin
			z_fold = z_raw - gip_pkg::DEG180;
			fold = 1'b1;
		end else if (z_raw < -gip_pkg::DEG90) begin
			z_fold = z_raw + gip_pkg::DEG180;
			fold = 1'b1;
		end
	end

	assign dx = cy_q >>> iter_q;
	assign dy = cx_q >>> iter_q;
	assign at = gip_pkg::atan_deg(iter_q);
	assign tc = to_trig(cx_q, flip_q);
	assign ts = to_trig(cy_q, flip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			sel_q <= 1'b0;
			iter_q <= '0;
			settle_q <= '0;
		end else if (cfg_we && cfg_addr <= gip_pkg::REG_YAW) begin
			st_q <= S_LOAD;
			sel_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: ;
				S_LOAD: begin
					st_q <= S_RUN;
					iter_q <= '0;
				end
				S_RUN: begin
					if (iter_q == gip_pkg::ITER_W'(N_ITER - 1)) begin
						st_q <= S_STORE;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_STORE: begin
					if (!sel_q) begin
						sel_q <= 1'b1;
						st_q <= S_LOAD;
					end else begin
						st_q <= S_SETTLE;
						settle_q <= '0;
					end
				end
				S_SETTLE: begin
					if (settle_q == 2'd2) begin
						st_q <= S_IDLE;
					end else begin
						settle_q <= settle_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_LOAD) begin
			cx_q <= gip_pkg::CORDIC_GAIN;
			cy_q <= '0;
			cz_q <= z_fold;
			flip_q <= fold;
		end else if (st_q == S_RUN) begin
			if (!cz_q[ZW-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			s1_q <= '0;
			c2_q <= '0;
			s2_q <= '0;
		end else if (st_q == S_STORE) begin
			if (!sel_q) begin
				c1_q <= tc;
				s1_q <= ts;
			end else begin
				c2_q <= tc;
				s2_q <= ts;
			end
		end
	end

	assign busy = (st_q != S_IDLE);

	// ---------------------------------------------------------------
	// Matrix setup pipeline. It runs freely; the settle cycles of the
	// sequencer cover its three stages.
	// ---------------------------------------------------------------
	logic signed [gip_pkg::PIX_W:0] fx, fy, cxp, cyp;
	assign fx = signed'({1'b0, focal_x_q});
	assign fy = signed'({1'b0, focal_y_q});
	assign cxp = signed'({1'b0, center_x_q});
	assign cyp = signed'({1'b0, center_y_q});

	logic signed [33:0] kfxc2_s1, kfxs2_s1, kfys1_s1, kfyc1_s1;
	logic signed [33:0] ks1cy_s1, kc1cy_s1, ks1cx_s1;
	logic signed [39:0] kc1s2_s1, kc1c2_s1;
	logic signed [TW-1:0] ks1_s1, kc2_s1, ks2_s1;
	logic signed [gip_pkg::PIX_W:0] kcx_s1;

	logic signed [MW-1:0] m00_s2, m01_s2, m02_s2, m12_s2, m20_s2, m21_s2, m22_s2;
	logic signed [QV_W-1:0] kq_s2;
	logic signed [TW-1:0] kc2_s2, ks2_s2;

	logic signed [MW-1:0] m_s3 [3][3];

	always_ff @(posedge clk) begin
		kfxc2_s1 <= fx * c2_q;
		kfxs2_s1 <= fx * s2_q;
		kfys1_s1 <= fy * s1_q;
		kfyc1_s1 <= fy * c1_q;
		ks1cy_s1 <= s1_q * cyp;
		kc1cy_s1 <= c1_q * cyp;
		ks1cx_s1 <= s1_q * cxp;
		kc1s2_s1 <= c1_q * s2_q;
		kc1c2_s1 <= c1_q * c2_q;
		ks1_s1 <= s1_q;
		kc2_s1 <= c2_q;
		ks2_s1 <= s2_q;
		kcx_s1 <= cxp;

		m00_s2 <= (MW'(kfxc2_s1) <<< TS) + MW'(kc1s2_s1) * MW'(kcx_s1);
		m01_s2 <= MW'(kc1c2_s1) * MW'(kcx_s1) - (MW'(kfxs2_s1) <<< TS);
		m02_s2 <= -(MW'(ks1cx_s1) <<< TS);
		kq_s2 <= QV_W'(kc1cy_s1) - QV_W'(kfys1_s1);
		m12_s2 <= -((MW'(kfyc1_s1) + MW'(ks1cy_s1)) <<< TS);
		m20_s2 <= MW'(kc1s2_s1);
		m21_s2 <= MW'(kc1c2_s1);
		m22_s2 <= -(MW'(ks1_s1) <<< TS);
		kc2_s2 <= kc2_s1;
		ks2_s2 <= ks2_s1;

		m_s3[0][0] <= m00_s2;
		m_s3[0][1] <= m01_s2;
		m_s3[0][2] <= m02_s2;
		m_s3[1][0] <= MW'(ks2_s2) * MW'(kq_s2);
		m_s3[1][1] <= MW'(kc2_s2) * MW'(kq_s2);
		m_s3[1][2] <= m12_s2;
		m_s3[2][0] <= m20_s2;
		m_s3[2][1] <= m21_s2;
		m_s3[2][2] <= m22_s2;
	end

	// ---------------------------------------------------------------
	// Projection pipeline. Each matrix entry is split in two halves so
	// that every multiplier stays within 27 by 32 bits.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s41;
	logic [QW:0] dv_v_s;

	logic signed [PW-1:0] px_s1, py_s1;
	logic signed [PW-1:0] pin [3];
	logic signed [PPW-1:0] pl_s2 [3][3];
	logic signed [PPW-1:0] ph_s2 [3][3];
	logic signed [RW-1:0] prod_s3 [3][3];
	logic signed [RW-1:0] sa_s4 [3];
	logic signed [RW-1:0] sb_s4 [3];
	logic signed [RW-1:0] row_s5 [3];
	logic [RW-1:0] abs0_s6, abs1_s6, abs2_s6;
	logic negu_s6, negv_s6, zero_s6;
	logic [NW-1:0] nu_s7, nv_s7;
	logic [DW-1:0] d_s7;
	logic negu_s7, negv_s7, zero_s7;

	// Divider lanes; index 0 is stage 8, index j is stage 8 + j.
	logic [DW-1:0] ru_s [0:QW];
	logic [DW-1:0] rv_s [0:QW];
	logic [QW-1:0] lu_s [0:QW];
	logic [QW-1:0] lv_s [0:QW];
	logic [QW-1:0] qu_s [0:QW];
	logic [QW-1:0] qv_s [0:QW];
	logic [DW-1:0] d_s [0:QW];
	logic ovfu_s [0:QW];
	logic ovfv_s [0:QW];
	logic negu_s [0:QW];
	logic negv_s [0:QW];
	logic zero_s [0:QW];

	localparam int OUT_W_L = gip_pkg::OUT_W;
	logic signed [OUT_W_L-1:0] pu_s41, pv_s41;
	logic fault_s41;

	assign pin[0] = px_s1;
	assign pin[1] = py_s1;
	assign pin[2] = PW'(0) - signed'({1'b0, mount_q});

	function automatic logic [RW-1:0] abs_row(input logic signed [RW-1:0] r);
		abs_row = r[RW-1] ? RW'(-r) : RW'(r);
	endfunction

	function automatic logic div_ge(input logic [DW-1:0] r, input logic b,
		input logic [DW-1:0] d);
		div_ge = ({r, b} >= {1'b0, d});
	endfunction

	function automatic logic [DW-1:0] div_rem(input logic [DW-1:0] r, input logic b,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		div_rem = t[DW-1:0];
	endfunction

	// Saturate the magnitude to the signed output range and apply the sign.
	function automatic logic [QW-1:0] sat_out(input logic [QW-1:0] q, input logic ovf,
		input logic neg);
		if (neg) begin
			if (ovf || (q[QW-1] && (|q[QW-2:0]))) begin
				sat_out = {1'b1, {(QW-1){1'b0}}};
			end else begin
				sat_out = QW'(0) - q;
			end
		end else begin
			if (ovf || q[QW-1]) begin
				sat_out = {1'b0, {(QW-1){1'b1}}};
			end else begin
				sat_out = q;
			end
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dv_v_s <= '0;
			v_s41 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			dv_v_s <= {dv_v_s[QW-1:0], v_s7};
			v_s41 <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			px_s1 <= ground_x;
			py_s1 <= ground_y;
		end

		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				pl_s2[k][j] <= PPW'(signed'({1'b0, m_s3[k][j][LO_W-1:0]})) * PPW'(pin[j]);
				ph_s2[k][j] <= PPW'(signed'(m_s3[k][j][MW-1:LO_W])) * PPW'(pin[j]);
				prod_s3[k][j] <= (RW'(ph_s2[k][j]) <<< LO_W) + RW'(pl_s2[k][j]);
			end
			sa_s4[k] <= prod_s3[k][0] + prod_s3[k][1];
			sb_s4[k] <= prod_s3[k][2];
			row_s5[k] <= sa_s4[k] + sb_s4[k];
		end

		abs0_s6 <= abs_row(row_s5[0]);
		abs1_s6 <= abs_row(row_s5[1]);
		abs2_s6 <= abs_row(row_s5[2]);
		negu_s6 <= row_s5[0][RW-1] ^ row_s5[2][RW-1];
		negv_s6 <= row_s5[1][RW-1] ^ row_s5[2][RW-1];
		zero_s6 <= (row_s5[2] == '0);

		// Rounded quotient: (|n| * 2^(F+1) + |d|) / (2 |d|).
		nu_s7 <= (NW'(abs0_s6) << (FRAC_BITS + 1)) + NW'(abs2_s6);
		nv_s7 <= (NW'(abs1_s6) << (FRAC_BITS + 1)) + NW'(abs2_s6);
		d_s7 <= DW'(abs2_s6) << 1;
		negu_s7 <= negu_s6;
		negv_s7 <= negv_s6;
		zero_s7 <= zero_s6;

		// A quotient of 2^32 or more only matters as saturation.
		ovfu_s[0] <= (nu_s7 >> QW) >= NW'(d_s7);
		ovfv_s[0] <= (nv_s7 >> QW) >= NW'(d_s7);
		ru_s[0] <= DW'(nu_s7 >> QW);
		rv_s[0] <= DW'(nv_s7 >> QW);
		lu_s[0] <= nu_s7[QW-1:0];
		lv_s[0] <= nv_s7[QW-1:0];
		qu_s[0] <= '0;
		qv_s[0] <= '0;
		d_s[0] <= d_s7;
		negu_s[0] <= negu_s7;
		negv_s[0] <= negv_s7;
		zero_s[0] <= zero_s7;

		// One quotient bit per stage, restoring division.
		for (int j = 1; j <= QW; j++) begin
			ru_s[j] <= div_rem(ru_s[j-1], lu_s[j-1][QW-1], d_s[j-1]);
			rv_s[j] <= div_rem(rv_s[j-1], lv_s[j-1][QW-1], d_s[j-1]);
			qu_s[j] <= {qu_s[j-1][QW-2:0], div_ge(ru_s[j-1], lu_s[j-1][QW-1], d_s[j-1])};
			qv_s[j] <= {qv_s[j-1][QW-2:0], div_ge(rv_s[j-1], lv_s[j-1][QW-1], d_s[j-1])};
			lu_s[j] <= lu_s[j-1] << 1;
			lv_s[j] <= lv_s[j-1] << 1;
			d_s[j] <= d_s[j-1];
			ovfu_s[j] <= ovfu_s[j-1];
			ovfv_s[j] <= ovfv_s[j-1];
			negu_s[j] <= negu_s[j-1];
			negv_s[j] <= negv_s[j-1];
			zero_s[j] <= zero_s[j-1];
		end

		// A zero divisor gives zero results and raises the fault flag.
		if (zero_s[QW]) begin
			pu_s41 <= '0;
			pv_s41 <= '0;
		end else begin
			pu_s41 <= sat_out(qu_s[QW], ovfu_s[QW], negu_s[QW]);
			pv_s41 <= sat_out(qv_s[QW], ovfv_s[QW], negv_s[QW]);
		end
		fault_s41 <= zero_s[QW];
	end

	assign done = v_s41;
	assign pixel_u = pu_s41;
	assign pixel_v = pv_s41;
	assign divide_fault = fault_s41;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result transfer missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result transfer without a matching input transfer");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_addr <= gip_pkg::REG_YAW) |=> busy)
		else $error("register write did not restart the setup");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_fault) |-> (pixel_u == '0 && pixel_v == '0))
		else $error("faulted result is not zero");
`endif

endmodule

>>> verif/ground_to_image_projection_tb.sv
// Self-checking testbench for ground_to_image_projection.
// Depends on gip_pkg and the block itself; it predicts every result on its own.

// How the run goes: a reset, then a short directed table of register
// writes and ground points, then eight random phases. Each phase first writes a
// new camera setup while the block is idle, then streams random ground points.
// Every accepted point without a typed result is run through a local projection
// model at the edge where it is taken, and the expected pixel lands in a queue.
// Each done strobe pops the oldest expectation and compares all three fields.
// Inputs change on the falling edge and outputs are sampled on the rising
// edge, so no check depends on the order of events inside one time step.
module ground_to_image_projection_tb;

	// There is no register at this index, so a write to it must change nothing.
	localparam logic [gip_pkg::ADDR_W-1:0] REG_NONE = 3'd7;
	localparam int N_ITER = (gip_pkg::FRAC_BITS_DEF > 0 && gip_pkg::TRIG_ITER_DEF < 24) ?
		gip_pkg::TRIG_ITER_DEF : 24;
	localparam longint RIGHT_ANGLE = 64'sd5898240;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint UNIT_GAIN = 64'sd652032874;
	localparam longint TRIG_UNIT = 64'sd262144;
	localparam longint ARCTAN [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT = 60;

	typedef struct packed {
		logic signed [gip_pkg::OUT_W-1:0] u;
		logic signed [gip_pkg::OUT_W-1:0] v;
		logic                             fault;
	} pixel_t;

	typedef struct {
		bit                               is_write;
		logic [gip_pkg::ADDR_W-1:0]       addr;
		logic [gip_pkg::DATA_W-1:0]       data;
		logic signed [gip_pkg::GND_W-1:0] gx;
		logic signed [gip_pkg::GND_W-1:0] gy;
		bit                               known;
		pixel_t                           want;
	} plan_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [gip_pkg::ADDR_W-1:0]       cfg_addr;
	logic [gip_pkg::DATA_W-1:0]       cfg_wdata;
	logic                             start;
	logic                             busy;
	logic signed [gip_pkg::GND_W-1:0] ground_x;
	logic signed [gip_pkg::GND_W-1:0] ground_y;
	logic                             done;
	logic signed [gip_pkg::OUT_W-1:0] pixel_u;
	logic signed [gip_pkg::OUT_W-1:0] pixel_v;
	logic                             divide_fault;

	// Local copy of the camera setup, with cosines and sines in Q1.18.
	longint cam_fx, cam_fy, cam_cx, cam_cy, cam_height;
	longint cos_pitch, sin_pitch, cos_yaw, sin_yaw;

	pixel_t pending_pixels[$];
	int     errors;
	int     cycles;
	bit     idle_enabled;

	ground_to_image_projection dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy), .ground_x(ground_x),
		.ground_y(ground_y), .done(done), .pixel_u(pixel_u), .pixel_v(pixel_v),
		.divide_fault(divide_fault)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Cosine and sine of a Q8.16 degree angle by CORDIC. Angles beyond a right
	// angle are folded by half a turn and both results are negated after.
	task automatic angle_trig(input logic [gip_pkg::ANG_W-1:0] raw, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'($signed(raw));
		x = UNIT_GAIN;
		y = 0;
		flip = 1'b0;
		if (z > RIGHT_ANGLE) begin
			z -= HALF_TURN;
			flip = 1'b1;
		end else if (z < -RIGHT_ANGLE) begin
			z += HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < N_ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN[i];
			end
		end
		x = (x + 2048) >>> 12;
		y = (y + 2048) >>> 12;
		if (x > TRIG_UNIT) x = TRIG_UNIT;
		if (x < -TRIG_UNIT) x = -TRIG_UNIT;
		if (y > TRIG_UNIT) y = TRIG_UNIT;
		if (y < -TRIG_UNIT) y = -TRIG_UNIT;
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Quotient rounded half away from zero to Q16.16, saturated to 32 bits.
	function automatic logic signed [gip_pkg::OUT_W-1:0] rounded_ratio(
			input logic signed [127:0] n, input logic signed [127:0] d);
		logic [127:0] na, da, q;
		bit neg;
		neg = (n < 0) != (d < 0);
		na = (n < 0) ? -n : n;
		da = (d < 0) ? -d : d;
		q = ((na << (gip_pkg::FRAC_BITS_DEF + 1)) + da) / (da << 1);
		if (neg)
			return (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
		return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
	endfunction

	// Projects one ground point with the current camera setup.
	function automatic pixel_t project_point(input logic signed [gip_pkg::GND_W-1:0] gx,
			input logic signed [gip_pkg::GND_W-1:0] gy);
		longint sh, q, m00, m01, m02, m10, m11, m12, m20, m21, m22;
		logic signed [127:0] px, py, pz, r0, r1, r2;
		pixel_t p;
		sh = 64'sd262144;
		m00 = cam_fx * cos_yaw * sh + cos_pitch * sin_yaw * cam_cx;
		m01 = -cam_fx * sin_yaw * sh + cos_pitch * cos_yaw * cam_cx;
		m02 = -sin_pitch * cam_cx * sh;
		q = cos_pitch * cam_cy - cam_fy * sin_pitch;
		m10 = sin_yaw * q;
		m11 = cos_yaw * q;
		m12 = (-cam_fy * cos_pitch - sin_pitch * cam_cy) * sh;
		m20 = cos_pitch * sin_yaw;
		m21 = cos_pitch * cos_yaw;
		m22 = -sin_pitch * sh;
		px = gx;
		py = gy;
		pz = -cam_height;
		r0 = 128'(signed'(m00)) * px + 128'(signed'(m01)) * py + 128'(signed'(m02)) * pz;
		r1 = 128'(signed'(m10)) * px + 128'(signed'(m11)) * py + 128'(signed'(m12)) * pz;
		r2 = 128'(signed'(m20)) * px + 128'(signed'(m21)) * py + 128'(signed'(m22)) * pz;
		if (r2 == 0) begin
			p.u = '0;
			p.v = '0;
			p.fault = 1'b1;
		end else begin
			p.u = rounded_ratio(r0, r2);
			p.v = rounded_ratio(r1, r2);
			p.fault = 1'b0;
		end
		return p;
	endfunction

	task automatic reset_camera();
		cam_fx = gip_pkg::FOCAL_X_RST;
		cam_fy = gip_pkg::FOCAL_Y_RST;
		cam_cx = gip_pkg::CENTER_X_RST;
		cam_cy = gip_pkg::CENTER_Y_RST;
		cam_height = gip_pkg::MOUNT_RST;
		angle_trig('0, cos_pitch, sin_pitch);
		angle_trig('0, cos_yaw, sin_yaw);
	endtask

	// Waits for every expected pixel, lets the pipeline settle, then writes one
	// register. Called at a falling edge and returns at one.
	task automatic write_reg(input logic [gip_pkg::ADDR_W-1:0] addr,
			input logic [gip_pkg::DATA_W-1:0] data);
		start <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		case (addr)
			gip_pkg::REG_FOCAL_X: cam_fx = data[12:0];
			gip_pkg::REG_FOCAL_Y: cam_fy = data[12:0];
			gip_pkg::REG_CENTER_X: cam_cx = data[12:0];
			gip_pkg::REG_CENTER_Y: cam_cy = data[12:0];
			gip_pkg::REG_MOUNT: cam_height = data[30:0];
			gip_pkg::REG_PITCH: angle_trig(data[gip_pkg::ANG_W-1:0], cos_pitch, sin_pitch);
			gip_pkg::REG_YAW: angle_trig(data[gip_pkg::ANG_W-1:0], cos_yaw, sin_yaw);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one point until it is taken; the expectation is queued at the
	// rising edge of the transfer. Called at a falling edge and returns at one.
	task automatic send_point(input logic signed [gip_pkg::GND_W-1:0] gx,
			input logic signed [gip_pkg::GND_W-1:0] gy, input bit known, input pixel_t want);
		pixel_t queued;
		while (idle_enabled && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		ground_x <= gx;
		ground_y <= gy;
		do
			@(posedge clk);
		while (busy);
		queued = known ? want : project_point(gx, gy);
		pending_pixels = {pending_pixels, queued};
		@(negedge clk);
	endtask

	// A random ground coordinate: usually a plausible distance, sometimes any
	// 32-bit value so that every input bit toggles and results saturate.
	function automatic logic signed [gip_pkg::GND_W-1:0] pick_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(200 << 16)) - (100 << 16);
			2: return $signed($urandom_range(4096)) - 2048;
			default: return $signed($urandom_range(60 << 16));
		endcase
	endfunction

	function automatic logic [gip_pkg::DATA_W-1:0] pick_angle();
		case ($urandom_range(5))
			0: return 31'(RIGHT_ANGLE);
			1: return 31'(-RIGHT_ANGLE) & 31'hFF_FFFF;
			2: return 31'($urandom);
			3: return 31'($urandom_range(24'h7F_FFFF, 24'h80_0000)) & 31'hFF_FFFF;
			default: return 31'($signed($urandom_range(40 << 16)) - (20 << 16)) & 31'hFF_FFFF;
		endcase
	endfunction

	function automatic logic [gip_pkg::DATA_W-1:0] pick_pixel(input int lo);
		case ($urandom_range(3))
			0: return 31'(lo);
			1: return 31'd8191;
			default: return 31'($urandom_range(8191, lo));
		endcase
	endfunction

	// Each result is compared with the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result u=%h v=%h fault=%b", $time, pixel_u,
					pixel_v, divide_fault);
			end else begin
				pixel_t w;
				w = pending_pixels.pop_front();
				if (pixel_u !== w.u) begin
					errors++;
					$display("%0t: pixel_u expected %h actual %h", $time, w.u, pixel_u);
				end
				if (pixel_v !== w.v) begin
					errors++;
					$display("%0t: pixel_v expected %h actual %h", $time, w.v, pixel_v);
				end
				if (divide_fault !== w.fault) begin
					errors++;
					$display("%0t: divide_fault expected %b actual %b", $time, w.fault,
						divide_fault);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		plan_row_t plan[$];
		pixel_t zero_fault;
		errors = 0;
		cycles = 0;
		idle_enabled = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		ground_x = '0;
		ground_y = '0;
		reset_camera();
		zero_fault = '{u: '0, v: '0, fault: 1'b1};

		// Directed part. A camera at zero height looking at the origin gives a
		// zero divisor whatever the angles, so those rows carry a typed result.
		plan = '{
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, 32'sd655360, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd65536, 32'sd655360, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sh8000_0000, 32'sh8000_0000, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, -32'sd655360, -32'sd655360, 0, '0},
			'{1, gip_pkg::REG_MOUNT, 31'd0, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, 32'sd0, 1, zero_fault},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd65536, 32'sd0, 0, '0},
			'{1, gip_pkg::REG_PITCH, 31'(RIGHT_ANGLE), 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, 32'sd0, 1, zero_fault},
			'{1, gip_pkg::REG_YAW, 31'h80_0000, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, 32'sd0, 1, zero_fault},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd327680, -32'sd327680, 0, '0},
			'{1, gip_pkg::REG_MOUNT, 31'h7FFF_FFFF, 0, 0, 0, '0},
			'{1, gip_pkg::REG_PITCH, 31'h7F_FFFF, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, 32'sd1310720, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd0, -32'sd1310720, 0, '0},
			'{1, gip_pkg::REG_PITCH, 31'hF0_0000, 0, 0, 0, '0},
			'{1, gip_pkg::REG_FOCAL_X, 31'd8191, 0, 0, 0, '0},
			'{1, gip_pkg::REG_FOCAL_Y, 31'd1, 0, 0, 0, '0},
			'{1, gip_pkg::REG_CENTER_X, 31'd0, 0, 0, 0, '0},
			'{1, gip_pkg::REG_CENTER_Y, 31'd8191, 0, 0, 0, '0},
			'{1, REG_NONE, 31'h7FFF_FFFF, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sd131072, 32'sd655360, 0, '0},
			'{1, gip_pkg::REG_FOCAL_X, 31'd0, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, -32'sd131072, 32'sd3276800, 0, '0},
			'{1, gip_pkg::REG_YAW, 31'hFF_FFFF, 0, 0, 0, '0},
			'{0, gip_pkg::REG_FOCAL_X, 0, 32'sh1234_5678, -32'sh0765_4321, 0, '0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].addr, plan[i].data);
			else
				send_point(plan[i].gx, plan[i].gy, plan[i].known, plan[i].want);
		end

		// Random phases: a fresh camera setup, then a stream of points. The
		// fourth phase runs with no sender gaps at all, and in the second one
		// the sender holds off mid-stream until every result is back.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(gip_pkg::REG_FOCAL_X, pick_pixel(1));
			write_reg(gip_pkg::REG_FOCAL_Y, pick_pixel(1));
			write_reg(gip_pkg::REG_CENTER_X, pick_pixel(0));
			write_reg(gip_pkg::REG_CENTER_Y, pick_pixel(0));
			case ($urandom_range(3))
				0: write_reg(gip_pkg::REG_MOUNT, 31'h7FFF_FFFF);
				1: write_reg(gip_pkg::REG_MOUNT, 31'($urandom));
				default: write_reg(gip_pkg::REG_MOUNT, 31'($urandom_range(5 << 16, 1 << 15)));
			endcase
			write_reg(gip_pkg::REG_PITCH, pick_angle());
			write_reg(gip_pkg::REG_YAW, pick_angle());
			idle_enabled = (ph != 3);
			for (int k = 0; k < 175; k++) begin
				if (ph == 1 && k == 90) begin
					start <= 1'b0;
					while (pending_pixels.size() != 0)
						@(negedge clk);
				end
				send_point(pick_coord(), pick_coord(), 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> ground_to_image_projection.f
design/gip_pkg.sv
design/ground_to_image_projection.sv
verif/ground_to_image_projection_tb.sv
